>>> design/vfam_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vfam_pkg
// Types and constant tables for the voxel face / ambient-occlusion mesher.
// ---------------------------------------------------------------------------
package vfam_pkg;

	localparam int unsigned NUM_FACES = 6;
	localparam int unsigned NUM_RING  = 8;
	localparam int unsigned NUM_VERTS = 6;

	localparam logic [2:0] FACE_TOP    = 3'd0;
	localparam logic [2:0] FACE_BOTTOM = 3'd1;
	localparam logic [2:0] FACE_RIGHT  = 3'd2;
	localparam logic [2:0] FACE_LEFT   = 3'd3;
	localparam logic [2:0] FACE_BACK   = 3'd4;
	localparam logic [2:0] FACE_FRONT  = 3'd5;

	localparam logic [2:0] LAST_VERT = 3'd5;

	typedef struct packed {
		logic [5:0]  pos_x;
		logic [5:0]  pos_y;
		logic [5:0]  pos_z;
		logic [7:0]  block_kind;
		logic [26:0] neighbor_solid;
	} item_t;

	// Mask bit of the cell across each face.
	localparam logic [4:0] FACE_BIT [NUM_FACES] = '{
		5'd22, 5'd4, 5'd14, 5'd12, 5'd10, 5'd16
	};

	// Mask bits of the eight ring cells a..h around each face neighbor.
	localparam logic [4:0] RING_BIT [NUM_FACES][NUM_RING] = '{
		'{5'd19, 5'd18, 5'd21, 5'd24, 5'd25, 5'd26, 5'd23, 5'd20},
		'{5'd1,  5'd0,  5'd3,  5'd6,  5'd7,  5'd8,  5'd5,  5'd2},
		'{5'd11, 5'd2,  5'd5,  5'd8,  5'd17, 5'd26, 5'd23, 5'd20},
		'{5'd9,  5'd0,  5'd3,  5'd6,  5'd15, 5'd24, 5'd21, 5'd18},
		'{5'd9,  5'd0,  5'd1,  5'd2,  5'd11, 5'd20, 5'd19, 5'd18},
		'{5'd15, 5'd6,  5'd7,  5'd8,  5'd17, 5'd26, 5'd25, 5'd24}
	};

	// Corner offsets {dx, dy, dz} of the four quad corners.
	localparam logic [2:0] CORNER_OFS [NUM_FACES][4] = '{
		'{3'b010, 3'b110, 3'b111, 3'b011},
		'{3'b000, 3'b100, 3'b101, 3'b001},
		'{3'b100, 3'b110, 3'b111, 3'b101},
		'{3'b000, 3'b010, 3'b011, 3'b001},
		'{3'b000, 3'b010, 3'b110, 3'b100},
		'{3'b001, 3'b011, 3'b111, 3'b101}
	};

	// Corner sequence of the two triangles, per face and flip.
	localparam logic [1:0] VERT_ORDER [NUM_FACES][2][NUM_VERTS] = '{
		'{'{2'd0, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2}},
		'{'{2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2}, '{2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3}},
		'{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
		'{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}},
		'{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
		'{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}}
	};

endpackage
`default_nettype wire

>>> design/vfam_voxel_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vfam_voxel_if
// Voxel request channel: position, id and 3x3x3 solid mask.
// ---------------------------------------------------------------------------
interface vfam_voxel_if;
	logic        valid;
	logic        ready;
	logic [5:0]  pos_x;
	logic [5:0]  pos_y;
	logic [5:0]  pos_z;
	logic [7:0]  block_kind;
	logic [26:0] neighbor_solid;

	modport source (
		output valid, pos_x, pos_y, pos_z, block_kind, neighbor_solid,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, block_kind, neighbor_solid,
		output ready
	);
endinterface
`default_nettype wire

>>> design/vfam_vertex_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vfam_vertex_if
// Vertex request channel: packed vertex word and end-of-voxel mark.
// ---------------------------------------------------------------------------
interface vfam_vertex_if;
	logic        valid;
	logic        ready;
	logic [31:0] vertex_word;
	logic        last_vertex;

	modport source (
		output valid, vertex_word, last_vertex,
		input  ready
	);
	modport sink (
		input  valid, vertex_word, last_vertex,
		output ready
	);
endinterface
`default_nettype wire

>>> design/vfam_vertex_gen.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vfam_vertex_gen
// Builds one packed vertex word: ring occlusion, flip and corner position.
// ---------------------------------------------------------------------------
module vfam_vertex_gen (
	input  vfam_pkg::item_t item,
	input  logic [2:0]      face,
	input  logic [2:0]      vert,
	output logic [31:0]     word
);

	logic [7:0] ring_void;
	logic [1:0] ao [4];
	logic       flip;
	logic [1:0] corner;
	logic [2:0] ofs;
	logic [5:0] cx, cy, cz;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ring_void[i] = ~item.neighbor_solid[vfam_pkg::RING_BIT[face][i]];
		end
	end

	assign ao[0] = {1'b0, ring_void[0]} + {1'b0, ring_void[1]} + {1'b0, ring_void[2]};
	assign ao[1] = {1'b0, ring_void[6]} + {1'b0, ring_void[7]} + {1'b0, ring_void[0]};
	assign ao[2] = {1'b0, ring_void[4]} + {1'b0, ring_void[5]} + {1'b0, ring_void[6]};
	assign ao[3] = {1'b0, ring_void[2]} + {1'b0, ring_void[3]} + {1'b0, ring_void[4]};

	// Split along the diagonal with the brighter pair of corners.
	assign flip = ({1'b0, ao[1]} + {1'b0, ao[3]}) > ({1'b0, ao[0]} + {1'b0, ao[2]});

	assign corner = vfam_pkg::VERT_ORDER[face][flip][vert];
	assign ofs    = vfam_pkg::CORNER_OFS[face][corner];

	// Six-bit adds wrap a coordinate of 64 to 0.
	assign cx = item.pos_x + {5'd0, ofs[2]};
	assign cy = item.pos_y + {5'd0, ofs[1]};
	assign cz = item.pos_z + {5'd0, ofs[0]};

	assign word = {cx, cy, cz, item.block_kind, face, ao[corner], flip};

endmodule
`default_nettype wire

>>> design/voxel_face_ao_mesher.sv
`default_nettype none
// ---------------------------------------------------------------------------
// voxel_face_ao_mesher
// Face culling and per-corner ambient occlusion for one voxel per request.
//
// The voxel channel takes a position, an id and the solid mask of the
// 3x3x3 neighborhood. The vertex channel returns six packed vertex words
// for every face whose neighbor is void, faces in the order top, bottom,
// right, left, back, front; last_vertex marks the final word of a voxel.
// A voxel with id zero, or with no void face neighbor, is taken and gives
// no words. A kept voxel is registered as the held voxel (item_s1), and
// each of its words is then registered into the output register (word_q).
// Throughput: one word per cycle while the receiver holds ready high; the
// rate is set by the single vertex generator behind the face/vertex
// counters. The next voxel is taken in the cycle its predecessor's last
// word moves into the output register.
// Stall: while the receiver holds ready low, the output register and the
// counters hold; the voxel channel stays blocked once a voxel is held.
// Reset clears the held voxel and the output valid; no words are pending.
// ---------------------------------------------------------------------------
module voxel_face_ao_mesher (
	input  wire logic    clk,
	input  wire logic    arst_n,
	vfam_voxel_if.sink   voxel,
	vfam_vertex_if.source vertex
);

	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} face_pick_t;

	function automatic face_pick_t pick_face(input logic [5:0] mask, input logic [2:0] from);
		face_pick_t res;
		res.found = 1'b0;
		res.idx   = vfam_pkg::FACE_TOP;
		for (int i = 5; i >= 0; i--) begin
			if (mask[i] && (3'(i) >= from)) begin
				res.found = 1'b1;
				res.idx   = 3'(i);
			end
		end
		return res;
	endfunction

	vfam_pkg::item_t item_s1;
	logic            item_vld_q;
	logic [5:0]      faces_q;
	logic [2:0]      face_q;
	logic [2:0]      vert_q;

	logic [31:0]     word_q;
	logic            last_q;
	logic            out_vld_q;

	vfam_pkg::item_t in_item;
	logic [5:0]      in_faces;
	logic            in_keep;
	face_pick_t      first_pick;
	face_pick_t      next_pick;
	logic            load_out;
	logic            face_done;
	logic            item_done;
	logic            accept;
	logic [31:0]     gen_word;

	assign in_item.pos_x          = voxel.pos_x;
	assign in_item.pos_y          = voxel.pos_y;
	assign in_item.pos_z          = voxel.pos_z;
	assign in_item.block_kind     = voxel.block_kind;
	assign in_item.neighbor_solid = voxel.neighbor_solid;

	always_comb begin
		for (int f = 0; f < 6; f++) begin
			in_faces[f] = ~voxel.neighbor_solid[vfam_pkg::FACE_BIT[f]];
		end
	end

	// Drop empty and fully enclosed voxels at the door.
	assign first_pick = pick_face(in_faces, vfam_pkg::FACE_TOP);
	assign in_keep    = (voxel.block_kind != 8'd0) && first_pick.found;
	assign next_pick  = pick_face(faces_q, face_q + 3'd1);

	assign load_out  = item_vld_q && (!out_vld_q || vertex.ready);
	assign face_done = (vert_q == vfam_pkg::LAST_VERT);
	assign item_done = face_done && !next_pick.found;

	assign voxel.ready = !item_vld_q || (load_out && item_done);
	assign accept      = voxel.valid && voxel.ready;

	vfam_vertex_gen u_gen (
		.item (item_s1),
		.face (face_q),
		.vert (vert_q),
		.word (gen_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			faces_q    <= '0;
			face_q     <= vfam_pkg::FACE_TOP;
			vert_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (vertex.ready) begin
				out_vld_q <= 1'b0;
			end

			if (accept) begin
				item_vld_q <= in_keep;
				faces_q    <= in_faces;
				face_q     <= first_pick.idx;
				vert_q     <= '0;
			end else if (load_out) begin
				if (item_done) begin
					item_vld_q <= 1'b0;
				end else if (face_done) begin
					face_q <= next_pick.idx;
					vert_q <= '0;
				end else begin
					vert_q <= vert_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (load_out) begin
			word_q <= gen_word;
			last_q <= item_done;
		end
	end

	assign vertex.valid       = out_vld_q;
	assign vertex.vertex_word = word_q;
	assign vertex.last_vertex = last_q;

endmodule
`default_nettype wire
